// File: src/tdma_slot_lease_manager_core_assert.svh
// Assertion macros for the slot-lease manager checker.
// Needs i_clk and i_rst_n in the scope of every use.
`ifndef TDMA_SLOT_LEASE_MANAGER_CORE_ASSERT_SVH
`define TDMA_SLOT_LEASE_MANAGER_CORE_ASSERT_SVH

// same-cycle implication, held off during reset
`define TSLM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, held off during reset
`define TSLM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: src/tslm_pkg.sv
// Shared types and codes for the TDMA slot-lease manager.
// No dependencies.
`default_nettype none

package tslm_pkg;

    // input function codes
    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_PKT   = 2'd1;
    localparam logic [1:0] FUNC_START = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_SYNC  = 2'd0;
    localparam logic [1:0] KIND_RESET = 2'd1;
    localparam logic [1:0] KIND_JOIN  = 2'd2;

    // configuration register indexes
    localparam logic REG_SYNC_SLOT = 1'b0;
    localparam logic REG_GRANT_TTL = 1'b1;

    localparam logic [7:0] TTL_MAX = 8'd255;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_AGE_RD,
        ST_AGE_CHK,
        ST_SYNC_OUT,
        ST_RST_OUT,
        ST_PKT_RD,
        ST_PKT_WR,
        ST_JOIN_RD,
        ST_JOIN_WR
    } t_state;

endpackage

`default_nettype wire

// File: src/tdma_slot_lease_manager_core.sv
// TDMA slot-lease manager, host side: lease table, slot sequencer and outputs.
// Depends on tslm_pkg.
`default_nettype none

// Keeps an 8-bit lease time-to-live per slot in a single-port-read,
// single-port-write memory (registered read) and the current slot.
// One input transaction is handled at a time. A frame tick or host start
// passes the idle state, which takes it, then the free-slot search, which
// reads one table entry per cycle through the memory read port and stops at
// the first free slot (pipelined against the registered read), then the
// aging of the slot that just ended (a read and a write), the sync and, if
// the lease expired while the queue has room, the reset command, one per
// cycle while the output side is ready. A client packet reads and refreshes
// the sender's lease, and with a join also reads the requested slot and
// gives a join response; an ignored packet or an unused function code is
// only taken in the idle state. Host start clears the table at once through
// per-slot valid bits; an entry that is not valid reads as zero. A result
// waits in the output register while the next input transaction is taken.
// Configuration: sync_slot at byte address 0, grant_ttl at byte address 4.
module tdma_slot_lease_manager_core
    import tslm_pkg::*;
#(
    parameter int SLOTS = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,  // sender_slot[2:0], requested_slot[10:3],
                                       // queue_has_room[11], zero[15:12]
    input  wire logic [2:0]  s_tuser,  // func[1:0], is_join[2]
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,  // slot[7:0], next_free[10:8], accepted[11],
                                       // lease_ttl[19:12], zero[23:20]
    output logic [1:0]       m_tuser,  // kind[1:0]
    output logic             m_tlast,
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int SW = $clog2(SLOTS);
    localparam logic [SW-1:0] LAST_IDX  = SW'(SLOTS - 1);
    localparam logic [7:0]    SLOTS_LIM = 8'(SLOTS);

    // configuration registers
    logic [2:0] r_sync_slot;
    logic [7:0] r_grant_ttl;
    logic       cfg_wr;
    logic [7:0] sync_ext;

    assign pready   = 1'b1;
    assign cfg_wr   = psel & penable & pwrite;
    assign sync_ext = {5'b0, r_sync_slot};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_slot <= 3'd0;
            r_grant_ttl <= 8'd3;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_SYNC_SLOT: r_sync_slot <= pwdata[2:0];
                REG_GRANT_TTL: r_grant_ttl <= pwdata[7:0];
                default:       ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_SYNC_SLOT: prdata = {29'd0, r_sync_slot};
            REG_GRANT_TTL: prdata = {24'd0, r_grant_ttl};
            default:       prdata = 32'd0;
        endcase
    end

    // lease table memory and per-slot valid bits
    logic [7:0]       mem [SLOTS];
    logic [SLOTS-1:0] r_valid;
    logic [7:0]       r_rd_data;
    logic             r_rd_vld;
    logic             rd_en;
    logic [SW-1:0]    rd_addr;
    logic             wr_en;
    logic [SW-1:0]    wr_addr;
    logic [7:0]       wr_data;
    logic [7:0]       lease_q;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    assign lease_q = r_rd_vld ? r_rd_data : 8'd0;

    // sequencer registers
    t_state        r_state, n_state;
    logic [SW-1:0] r_cur;
    logic [SW-1:0] r_srch_addr;
    logic [SW-1:0] r_srch_left;
    logic [SW-1:0] r_chk_addr;
    logic          r_chk_vld;
    logic [2:0]    r_nf;
    logic          r_rst_pend;
    logic [7:0]    r_snd;
    logic [7:0]    r_req;
    logic          r_room;
    logic          r_join;

    // output register
    logic       r_out_valid;
    logic [1:0] r_out_kind;
    logic [7:0] r_out_slot;
    logic [2:0] r_out_nf;
    logic       r_out_acc;
    logic [7:0] r_out_ttl;
    logic       r_out_last;
    logic       out_free;

    assign out_free = !r_out_valid || m_tready;
    assign m_tvalid = r_out_valid;
    assign m_tuser  = r_out_kind;
    assign m_tlast  = r_out_last;
    assign m_tdata  = {4'd0, r_out_ttl, r_out_acc, r_out_nf, r_out_slot};

    // input fields
    logic [1:0] in_func;
    logic [7:0] in_snd;
    logic       in_join;
    logic [7:0] in_req;
    logic       in_room;
    logic       in_acc;

    assign in_func  = s_tuser[1:0];
    assign in_join  = s_tuser[2];
    assign in_snd   = {5'd0, s_tdata[2:0]};
    assign in_req   = s_tdata[10:3];
    assign in_room  = s_tdata[11];
    assign s_tready = (r_state == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;

    // slot arithmetic
    logic [SW-1:0] cur_inc, cur_base, base_inc, prev, srch_inc;
    logic          cur_is_sync, prev_is_sync, chk_free;

    assign cur_inc      = (r_cur == LAST_IDX) ? '0 : r_cur + 1'b1;
    assign cur_base     = (in_func == FUNC_TICK) ? cur_inc : r_cur;
    assign base_inc     = (cur_base == LAST_IDX) ? '0 : cur_base + 1'b1;
    assign prev         = (r_cur == '0) ? LAST_IDX : r_cur - 1'b1;
    assign srch_inc     = (r_srch_addr == LAST_IDX) ? '0 : r_srch_addr + 1'b1;
    assign cur_is_sync  = (8'(r_cur) == sync_ext);
    assign prev_is_sync = (8'(prev) == sync_ext);
    assign chk_free     = r_chk_vld && (8'(r_chk_addr) != sync_ext) && (lease_q == 8'd0);

    // aging of the slot that just ended
    logic       age_hit, age_expire, age_rst;
    logic [7:0] age_dec;

    assign age_hit    = !prev_is_sync && (lease_q != 8'd0);
    assign age_dec    = lease_q - 8'd1;
    assign age_expire = age_hit && (age_dec == 8'd0);
    assign age_rst    = age_expire && r_room;

    // refresh of the sender and join decision
    logic [7:0] refresh_val;
    logic       join_ok;

    assign refresh_val = (lease_q < r_grant_ttl) ? r_grant_ttl :
                         (lease_q < TTL_MAX)     ? lease_q + 8'd1 : lease_q;
    assign join_ok     = (r_req < SLOTS_LIM) && (r_req != sync_ext) && (lease_q == 8'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and memory control
    always_comb begin
        n_state = r_state;
        rd_en   = 1'b0;
        rd_addr = r_srch_addr;
        wr_en   = 1'b0;
        wr_addr = prev;
        wr_data = age_dec;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    unique case (in_func) inside
                        FUNC_TICK, FUNC_START: n_state = ST_SEARCH;
                        FUNC_PKT: begin
                            if (!cur_is_sync && (in_snd < SLOTS_LIM)) begin
                                n_state = ST_PKT_RD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_SEARCH: begin
                rd_en = (r_srch_left != '0);
                if (chk_free || (r_srch_left == '0)) begin
                    n_state = ST_AGE_RD;
                end
            end
            ST_AGE_RD: begin
                rd_en   = 1'b1;
                rd_addr = prev;
                n_state = ST_AGE_CHK;
            end
            ST_AGE_CHK: begin
                // keep an expired lease at one when the queue is full
                wr_en   = age_hit && !(age_expire && !r_room);
                n_state = ST_SYNC_OUT;
            end
            ST_SYNC_OUT: begin
                if (out_free) begin
                    n_state = r_rst_pend ? ST_RST_OUT : ST_IDLE;
                end
            end
            ST_RST_OUT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_PKT_RD: begin
                rd_en   = 1'b1;
                rd_addr = r_snd[SW-1:0];
                n_state = ST_PKT_WR;
            end
            ST_PKT_WR: begin
                wr_en   = (lease_q != 8'd0);
                wr_addr = r_snd[SW-1:0];
                wr_data = refresh_val;
                n_state = r_join ? ST_JOIN_RD : ST_IDLE;
            end
            ST_JOIN_RD: begin
                rd_en   = 1'b1;
                rd_addr = r_req[SW-1:0];
                n_state = ST_JOIN_WR;
            end
            ST_JOIN_WR: begin
                wr_addr = r_req[SW-1:0];
                wr_data = r_grant_ttl;
                if (out_free) begin
                    wr_en   = join_ok;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control registers: current slot, valid bits, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur       <= '0;
            r_valid     <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (rd_en) begin
                r_rd_vld <= r_valid[rd_addr];
            end
            if (in_acc && (in_func == FUNC_TICK || in_func == FUNC_START)) begin
                r_cur <= cur_base;
            end
            // host start drops every lease at once
            if (in_acc && in_func == FUNC_START) begin
                r_valid <= '0;
            end else if (wr_en) begin
                r_valid[wr_addr] <= 1'b1;
            end
            if (out_free && (r_state == ST_SYNC_OUT || r_state == ST_RST_OUT ||
                             r_state == ST_JOIN_WR)) begin
                r_out_valid <= 1'b1;
            end else if (m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_srch_addr <= base_inc;
            r_srch_left <= LAST_IDX;
            r_chk_vld   <= 1'b0;
            r_nf        <= r_sync_slot;
            r_snd       <= in_snd;
            r_req       <= in_req;
            r_room      <= in_room;
            r_join      <= in_join;
        end
        if (r_state == ST_SEARCH) begin
            // read one entry ahead, check the one that just came back
            r_chk_vld <= (r_srch_left != '0);
            if (r_srch_left != '0) begin
                r_chk_addr  <= r_srch_addr;
                r_srch_addr <= srch_inc;
                r_srch_left <= r_srch_left - 1'b1;
            end
            if (chk_free) begin
                r_nf <= 3'(r_chk_addr);
            end
        end
        if (r_state == ST_AGE_CHK) begin
            r_rst_pend <= age_rst;
        end
        if (out_free) begin
            unique case (r_state)
                ST_SYNC_OUT: begin
                    r_out_kind <= KIND_SYNC;
                    r_out_slot <= 8'(r_cur);
                    r_out_nf   <= r_nf;
                    r_out_acc  <= 1'b0;
                    r_out_ttl  <= r_grant_ttl;
                    r_out_last <= !r_rst_pend;
                end
                ST_RST_OUT: begin
                    r_out_kind <= KIND_RESET;
                    r_out_slot <= 8'(prev);
                    r_out_nf   <= 3'd0;
                    r_out_acc  <= 1'b0;
                    r_out_ttl  <= 8'd0;
                    r_out_last <= 1'b1;
                end
                ST_JOIN_WR: begin
                    r_out_kind <= KIND_JOIN;
                    r_out_slot <= r_req;
                    r_out_nf   <= 3'd0;
                    r_out_acc  <= join_ok;
                    r_out_ttl  <= 8'd0;
                    r_out_last <= 1'b1;
                end
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: src/tslm_checker.sv
// Port-level checker for the slot-lease manager and its bind to the top level.
// Depends on tslm_pkg and tdma_slot_lease_manager_core_assert.svh.
`default_nettype none

`include "tdma_slot_lease_manager_core_assert.svh"

module tslm_checker
    import tslm_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata,
    input wire logic [1:0]  m_tuser,
    input wire logic        m_tlast
);

    // a result held back by the sink stays offered
    `TSLM_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")

    // a reset command always closes the transaction's results
    `TSLM_ASSERT_NOW(a_rst_last, m_tvalid && m_tuser == KIND_RESET, m_tlast, "reset not last")

    // a reset command carries only the slot
    `TSLM_ASSERT_NOW(a_rst_clean, m_tvalid && m_tuser == KIND_RESET, m_tdata[23:8] == 16'd0, "reset has stray fields")

    // a join response is single, with no sync fields
    `TSLM_ASSERT_NOW(a_join_form, m_tvalid && m_tuser == KIND_JOIN, m_tlast && m_tdata[10:8] == 3'd0 && m_tdata[19:12] == 8'd0, "bad join response")

endmodule

bind tdma_slot_lease_manager_core tslm_checker u_tslm_checker (.*);

`default_nettype wire
